/* rtl/hcbp_pkg.sv */
// Shared types and constants for the prefix-code bit packer.
// Holds the item kind codes, the sequencer control word and its microcode ROM.
// No dependencies.
package hcbp_pkg;

   localparam int KIND_W   = 2;
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 32;
   localparam int CLEN_W   = 6;
   localparam int BYTE_W   = 8;
   localparam int PEND_W   = 7;
   localparam int PCNT_W   = 3;
   localparam int CNT_W    = 6;   // pending bits plus a full code: up to 39
   localparam int STEP_W   = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,   // ready for a transfer, table writes happen here
      OP_NONE  = 3'd1,
      OP_LOAD  = 3'd2,   // merge looked-up code into the accumulator
      OP_EMIT  = 3'd3,   // drain whole bytes, then park the remainder
      OP_FLUSH = 3'd4    // push out the padded partial byte
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS  = 3'd0,
      COND_WORK    = 3'd1,   // accepted an encode or a flush
      COND_FLUSH   = 3'd2,   // the accepted item was a flush
      COND_MISS    = 3'd3,   // symbol has no code
      COND_DONE    = 3'd4,   // fewer than eight bits left
      COND_FLUSHED = 3'd5    // nothing pending, or the output can take it
   } cond_type;

   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DECODE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MERGE  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_FLUSH  = 3'd4;

   // Jump to target when cond holds; otherwise hold or fall through.
   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic                stay;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   function automatic ctrl_word_type microcode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      unique case (step)
         STEP_IDLE:   cw = '{op: OP_IDLE,  cond: COND_WORK,    stay: 1'b1, target: STEP_DECODE};
         STEP_DECODE: cw = '{op: OP_NONE,  cond: COND_FLUSH,   stay: 1'b0, target: STEP_FLUSH};
         STEP_MERGE:  cw = '{op: OP_LOAD,  cond: COND_MISS,    stay: 1'b0, target: STEP_IDLE};
         STEP_EMIT:   cw = '{op: OP_EMIT,  cond: COND_DONE,    stay: 1'b1, target: STEP_IDLE};
         STEP_FLUSH:  cw = '{op: OP_FLUSH, cond: COND_FLUSHED, stay: 1'b1, target: STEP_IDLE};
         default:     cw = '{op: OP_NONE,  cond: COND_ALWAYS,  stay: 1'b0, target: STEP_IDLE};
      endcase
      return cw;
   endfunction

endpackage

/* rtl/hcbp_req_if.sv */
// Input channel of the bit packer: valid/ready plus one input item.
// Depends on hcbp_pkg for field widths.
interface hcbp_req_if;
   import hcbp_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SYM_W-1:0]    symbol;
   logic [CODE_W-1:0]   code_bits;
   logic [CLEN_W-1:0]   code_length;

   modport source (output valid, kind, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

/* rtl/hcbp_rsp_if.sv */
// Result channel of the bit packer: valid/ready plus one packed byte.
// Depends on hcbp_pkg for field widths.
interface hcbp_rsp_if;
   import hcbp_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   byte_out;
   logic                last_of_run;

   modport source (output valid, byte_out, last_of_run, input ready);
   modport sink   (input valid, byte_out, last_of_run, output ready);
endinterface

/* rtl/huffman_code_bit_packer.sv */
// Prefix-code bit packer: table lookup, bit accumulation and byte output.
// Depends on hcbp_pkg, hcbp_req_if, hcbp_rsp_if and hcbp_ram.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    kind, symbol, code_bits, code_length
//   rsp_chan  out  valid/ready    byte_out, last_of_run
//
// Load or unknown kind: accept only. Encode: 0..4 output bytes; a symbol with
// no code returns to idle after merge. Steps: accept, decode, merge after
// the registered table read, one emit per byte, one to park the remainder; a flush
// swaps merge and emit for one flush step. Output stalls hold the emit/flush step.
// Synchronous reset clears the code-valid bits, the pending bits and the
// sequencer at once; the table needs no clearing pass.
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOLS      = 256
) (
   input  logic          clock,
   input  logic          reset,
   hcbp_req_if.sink      req_chan,
   hcbp_rsp_if.source    rsp_chan
);
   import hcbp_pkg::*;

   localparam int LEN_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
   localparam int ACC_W     = LEN_LIMIT + PEND_W;
   localparam int AW        = $clog2(SYMBOLS);
   localparam int ENTRY_W   = LEN_W + LEN_LIMIT;

   ctrl_word_type       cw;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                cond_true;

   logic                accept;
   logic                in_range;
   logic [AW-1:0]       idx;
   logic [LEN_W-1:0]    load_len;
   logic                ram_we, ram_re;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
   logic [LEN_W-1:0]    ram_len;
   logic [LEN_LIMIT-1:0] ram_code;

   logic [SYMBOLS-1:0]  code_valid_ff, code_valid_in;
   logic                hit_ff, hit_in;
   logic                flush_ff, flush_in;

   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PEND_W-1:0]   pending_bits_ff, pending_bits_in;
   logic [PCNT_W-1:0]   pending_count_ff, pending_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                enough;
   logic                miss;
   logic [CNT_W-1:0]    emit_shift;
   logic [ACC_W-1:0]    merged;
   logic [CNT_W-1:0]    merged_count;

   assign cw       = microcode(step_ff);
   assign req_chan.ready = (cw.op == OP_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign in_range = {1'b0, req_chan.symbol} < 9'(SYMBOLS);
   assign idx      = req_chan.symbol[AW-1:0];
   assign load_len = (req_chan.code_length > CLEN_W'(LEN_LIMIT))
                     ? LEN_W'(LEN_LIMIT) : LEN_W'(req_chan.code_length);

   assign ram_we    = accept && (req_chan.kind == KIND_LOAD) && in_range;
   assign ram_re    = accept && (req_chan.kind == KIND_ENCODE);
   assign ram_wdata = {load_len, req_chan.code_bits[LEN_LIMIT-1:0]};

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOLS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (idx),
      .rdata (ram_rdata)
   );

   assign ram_len  = ram_rdata[ENTRY_W-1:LEN_LIMIT];
   assign ram_code = ram_rdata[LEN_LIMIT-1:0];

   // Pending bits go above the code; unused code bits are masked off.
   assign merged = (ACC_W'(pending_bits_ff) << ram_len)
                 | (ACC_W'(ram_code) & ~({ACC_W{1'b1}} << ram_len));
   assign merged_count = CNT_W'(pending_count_ff) + CNT_W'(ram_len);

   assign miss       = !hit_ff || (ram_len == '0);
   assign enough     = count_ff >= CNT_W'(8);
   assign emit_shift = count_ff - CNT_W'(8);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      code_valid_in = code_valid_ff;
      hit_in        = hit_ff;
      flush_in      = flush_ff;
      if (ram_we) begin
         code_valid_in[idx] = 1'b1;
      end
      if (accept) begin
         hit_in   = in_range && code_valid_ff[idx];
         flush_in = (req_chan.kind == KIND_FLUSH);
      end
   end

   always_comb begin
      unique case (cw.cond)
         COND_ALWAYS:  cond_true = 1'b1;
         COND_WORK:    cond_true = accept && ((req_chan.kind == KIND_ENCODE)
                                              || (req_chan.kind == KIND_FLUSH));
         COND_FLUSH:   cond_true = flush_ff;
         COND_MISS:    cond_true = miss;
         COND_DONE:    cond_true = !enough;
         COND_FLUSHED: cond_true = (pending_count_ff == '0) || out_free;
         default:      cond_true = 1'b1;
      endcase
      if (cond_true) begin
         step_in = cw.target;
      end else if (cw.stay) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      acc_in           = acc_ff;
      count_in         = count_ff;
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in      = rsp_byte_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (cw.op)
         OP_LOAD: begin
            acc_in   = merged;
            count_in = merged_count;
         end
         OP_EMIT: begin
            if (enough) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = BYTE_W'(acc_ff >> emit_shift);
                  rsp_last_in  = count_ff < CNT_W'(16);
                  count_in     = emit_shift;
               end
            end else begin
               pending_bits_in  = PEND_W'(acc_ff) & ~({PEND_W{1'b1}} << count_ff[PCNT_W-1:0]);
               pending_count_in = count_ff[PCNT_W-1:0];
            end
         end
         OP_FLUSH: begin
            if ((pending_count_ff != '0) && out_free) begin
               // pad: shift left by 8 - count, which is -count in three bits
               rsp_valid_in     = 1'b1;
               rsp_byte_in      = BYTE_W'(pending_bits_ff)
                                  << (PCNT_W'(0) - pending_count_ff);
               rsp_last_in      = 1'b1;
               pending_bits_in  = '0;
               pending_count_in = '0;
            end
         end
         OP_IDLE, OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= STEP_IDLE;
         code_valid_ff    <= '0;
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         step_ff          <= step_in;
         code_valid_ff    <= code_valid_in;
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      flush_ff    <= flush_in;
      acc_ff      <= acc_in;
      count_ff    <= count_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.byte_out    = rsp_byte_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;
endmodule

/* rtl/hcbp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       re,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
